FILE: rtl/bcc_pkg.sv
package bcc_pkg;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 19;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ZERO  = 3'd0,
		REG_KP    = 3'd1,
		REG_KD    = 3'd2,
		REG_KV    = 3'd3,
		REG_KT    = 3'd4,
		REG_KH    = 3'd5,
		REG_LIMIT = 3'd6
	} cfg_idx_t;

	// Register values after reset
	localparam logic signed [12:0] RST_ZERO  = 13'sd624;
	localparam logic signed [18:0] RST_KP    = -19'sd64512;
	localparam logic signed [16:0] RST_KD    = -17'sd768;
	localparam logic signed [17:0] RST_KV    = -18'sd26214;
	localparam logic signed [16:0] RST_KT    = 17'sd2560;
	localparam logic signed [16:0] RST_KH    = 17'sd154;
	localparam logic [14:0]        RST_LIMIT = 15'd7000;

	// Control constants
	localparam int FALL_LIMIT   = 10240;
	localparam int SPEED_MAX    = 15;
	localparam int TURN_MAX     = 150;
	localparam int TURN_STEP    = 30;
	localparam int NEAR_DIST    = 50;
	localparam int INTEGRAL_MAX = 20000;

	// Reciprocal constants: divide by 10 and by 25, truncating, for the value ranges used.
	localparam int REC10       = 3355444;
	localparam int REC10_SHIFT = 25;
	localparam int REC25       = 5368710;
	localparam int REC25_SHIFT = 27;
	localparam int KV_SHIFT    = 19;
	localparam int UP_SHIFT    = 16;
	localparam int TURN_SHIFT  = 8;

	// Shared multiplier
	localparam int MUL_W  = 28;
	localparam int PROD_W = 2 * MUL_W;

	typedef struct packed {
		logic signed [12:0] zero;
		logic signed [18:0] kp;
		logic signed [16:0] kd;
		logic signed [17:0] kv;
		logic signed [16:0] kt;
		logic signed [16:0] kh;
		logic [14:0]        limit;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] left_count;
		logic signed [15:0] right_count;
		logic signed [16:0] roll;
		logic signed [15:0] pitch;
		logic signed [15:0] yaw;
		logic [11:0]        obst_dist;
		logic               fwd;
		logic               back;
		logic               lft;
		logic               rgt;
	} item_t;

	typedef struct packed {
		logic signed [15:0] left;
		logic signed [15:0] right;
		logic               bal;
	} res_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CHECK,
		ST_ERR,
		ST_FMUL,
		ST_FILT,
		ST_INTEG,
		ST_SPD,
		ST_VMUL,
		ST_VSCALE,
		ST_VDIV,
		ST_VOUT,
		ST_UPA,
		ST_UPP,
		ST_UPD,
		ST_UPSUM,
		ST_UPDIV,
		ST_TSUM,
		ST_TDIV,
		ST_DRIVE
	} state_t;

endpackage

FILE: rtl/bcc_cfg.sv
module bcc_cfg import bcc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.zero  <= RST_ZERO;
			cfg_q.kp    <= RST_KP;
			cfg_q.kd    <= RST_KD;
			cfg_q.kv    <= RST_KV;
			cfg_q.kt    <= RST_KT;
			cfg_q.kh    <= RST_KH;
			cfg_q.limit <= RST_LIMIT;
		end else if (wr_en) begin
			unique case (cfg_idx_t'(wr_index))
				REG_ZERO:  cfg_q.zero  <= wr_data[12:0];
				REG_KP:    cfg_q.kp    <= wr_data[18:0];
				REG_KD:    cfg_q.kd    <= wr_data[16:0];
				REG_KV:    cfg_q.kv    <= wr_data[17:0];
				REG_KT:    cfg_q.kt    <= wr_data[16:0];
				REG_KH:    cfg_q.kh    <= wr_data[16:0];
				REG_LIMIT: cfg_q.limit <= wr_data[14:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/bcc_mul.sv
module bcc_mul import bcc_pkg::*; (
	input  logic                     clk,
	input  logic signed [MUL_W-1:0]  a,
	input  logic signed [MUL_W-1:0]  b,
	output logic signed [PROD_W-1:0] prod
);

	logic signed [PROD_W-1:0] prod_q;

	// Product is registered; it is available in the cycle after the operands.
	always_ff @(posedge clk) begin
		prod_q <= a * b;
	end

	assign prod = prod_q;

endmodule

FILE: rtl/bcc_ctrl.sv
module bcc_ctrl import bcc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	input  item_t item,
	input  cfg_t  cfg,
	input  logic  res_ready,
	output logic  idle,
	output logic  done,
	output res_t  res
);

	state_t state_q, state_d;

	// Loop state
	logic               bal_q, pend_q;
	logic signed [4:0]  spd_q;
	logic signed [8:0]  trn_q;
	logic signed [17:0] filt_q;
	logic signed [15:0] integ_q;

	// Working registers
	logic               fall_q, hold_q, sign_q;
	logic [21:0]        mag_q;
	logic signed [18:0] v_q;
	logic signed [PROD_W-1:0] acc_q;
	logic signed [31:0] up_q, turn_q;

	logic signed [MUL_W-1:0]  mul_a, mul_b;
	logic signed [PROD_W-1:0] prod;

	bcc_mul u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	// Tilt check and target ramps
	logic signed [17:0] tilt;
	logic               now_bal;
	logic signed [5:0]  spd_sum, spd_new;
	logic signed [9:0]  trn_sum, trn_new;

	assign tilt    = 18'(item.roll) - 18'(cfg.zero);
	assign now_bal = (tilt <= 18'(FALL_LIMIT)) && (tilt >= -18'(FALL_LIMIT));

	always_comb begin
		spd_sum = (item.fwd || item.back) ? 6'(spd_q) : 6'sd0;
		if (item.fwd) begin
			spd_sum = (item.obst_dist < 12'(NEAR_DIST)) ? spd_sum - 6'sd1 : spd_sum + 6'sd1;
		end
		if (item.back) begin
			spd_sum = spd_sum - 6'sd1;
		end
		if (spd_sum > 6'(SPEED_MAX)) begin
			spd_new = 6'(SPEED_MAX);
		end else if (spd_sum < -6'(SPEED_MAX)) begin
			spd_new = -6'(SPEED_MAX);
		end else begin
			spd_new = spd_sum;
		end

		trn_sum = (item.lft || item.rgt) ? 10'(trn_q) : 10'sd0;
		if (item.lft) begin
			trn_sum = trn_sum - 10'(TURN_STEP);
		end
		if (item.rgt) begin
			trn_sum = trn_sum + 10'(TURN_STEP);
		end
		if (trn_sum > 10'(TURN_MAX)) begin
			trn_new = 10'(TURN_MAX);
		end else if (trn_sum < -10'(TURN_MAX)) begin
			trn_new = -10'(TURN_MAX);
		end else begin
			trn_new = trn_sum;
		end
	end

	// Filter input: 3 * error + 7 * previous filter value
	logic signed [17:0] err;
	logic signed [20:0] fsum, fsum_abs;

	assign err      = 18'(item.left_count) + 18'(item.right_count) - 18'(spd_q);
	assign fsum     = (21'(err) <<< 1) + 21'(err) + (21'(filt_q) <<< 3) - 21'(filt_q);
	assign fsum_abs = fsum[20] ? -fsum : fsum;

	// Filter output, divided by 10 through the reciprocal product
	logic [16:0]        fq;
	logic signed [17:0] filt_new;

	assign fq       = prod[REC10_SHIFT+16:REC10_SHIFT];
	assign filt_new = sign_q ? -$signed({1'b0, fq}) : $signed({1'b0, fq});

	// Integral with clamp
	logic signed [18:0] isum;
	logic signed [15:0] integ_new;

	assign isum = 19'(integ_q) + 19'(filt_q);
	always_comb begin
		if (isum > 19'(INTEGRAL_MAX)) begin
			integ_new = 16'(INTEGRAL_MAX);
		end else if (isum < -19'(INTEGRAL_MAX)) begin
			integ_new = -16'(INTEGRAL_MAX);
		end else begin
			integ_new = isum[15:0];
		end
	end

	// 200 * filter + integral
	logic signed [25:0] spd_in;

	assign spd_in = (26'(filt_q) <<< 7) + (26'(filt_q) <<< 6) + (26'(filt_q) <<< 3)
		+ 26'(integ_q);

	// Speed output scaling: magnitude over 2^19, then over 25
	logic signed [PROD_W-1:0] prod_abs;
	logic [17:0]              vq;
	logic signed [18:0]       v_new;

	assign prod_abs = prod[PROD_W-1] ? -prod : prod;
	assign vq       = prod[REC25_SHIFT+17:REC25_SHIFT];
	assign v_new    = sign_q ? -$signed({1'b0, vq}) : $signed({1'b0, vq});

	// Upright angle error
	logic signed [MUL_W-1:0] up_err;

	assign up_err = MUL_W'(item.roll) - MUL_W'(cfg.zero) - (MUL_W'(v_q) <<< 8);

	// Divisions by powers of two that truncate toward zero
	logic signed [PROD_W-1:0] up_bias, turn_bias, up_div, turn_div;

	assign up_bias   = acc_q[PROD_W-1] ? PROD_W'((1 << UP_SHIFT) - 1) : '0;
	assign turn_bias = acc_q[PROD_W-1] ? PROD_W'((1 << TURN_SHIFT) - 1) : '0;
	assign up_div    = (acc_q + up_bias) >>> UP_SHIFT;
	assign turn_div  = (acc_q + turn_bias) >>> TURN_SHIFT;

	// Drive mixing and saturation
	logic signed [32:0] lim, dl, dr, dl_sat, dr_sat;

	assign lim = 33'($signed({1'b0, cfg.limit}));
	assign dl  = 33'(up_q) - 33'(turn_q);
	assign dr  = 33'(up_q) + 33'(turn_q);

	always_comb begin
		if (dl > lim) begin
			dl_sat = lim;
		end else if (dl < -lim) begin
			dl_sat = -lim;
		end else begin
			dl_sat = dl;
		end
		if (dr > lim) begin
			dr_sat = lim;
		end else if (dr < -lim) begin
			dr_sat = -lim;
		end else begin
			dr_sat = dr;
		end
	end

	assign res.left  = fall_q ? 16'sd0 : dl_sat[15:0];
	assign res.right = fall_q ? 16'sd0 : dr_sat[15:0];
	assign res.bal   = !fall_q;

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		mul_a   = '0;
		mul_b   = '0;
		done    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK:  state_d = now_bal ? ST_ERR : ST_DRIVE;
			ST_ERR:    state_d = ST_FMUL;
			ST_FMUL: begin
				mul_a   = MUL_W'($signed({1'b0, mag_q}));
				mul_b   = MUL_W'(REC10);
				state_d = ST_FILT;
			end
			ST_FILT:   state_d = ST_INTEG;
			ST_INTEG:  state_d = ST_SPD;
			ST_SPD:    state_d = ST_VMUL;
			ST_VMUL: begin
				mul_a   = MUL_W'(cfg.kv);
				mul_b   = acc_q[MUL_W-1:0];
				state_d = ST_VSCALE;
			end
			ST_VSCALE: state_d = ST_VDIV;
			ST_VDIV: begin
				mul_a   = MUL_W'($signed({1'b0, mag_q}));
				mul_b   = MUL_W'(REC25);
				state_d = ST_VOUT;
			end
			ST_VOUT:   state_d = ST_UPA;
			ST_UPA:    state_d = ST_UPP;
			ST_UPP: begin
				mul_a   = MUL_W'(cfg.kp);
				mul_b   = acc_q[MUL_W-1:0];
				state_d = ST_UPD;
			end
			ST_UPD: begin
				mul_a   = MUL_W'(cfg.kd);
				mul_b   = MUL_W'(item.pitch);
				state_d = ST_UPSUM;
			end
			ST_UPSUM: begin
				mul_a   = MUL_W'(cfg.kt);
				mul_b   = MUL_W'(trn_q);
				state_d = ST_UPDIV;
			end
			ST_UPDIV: begin
				mul_a   = hold_q ? MUL_W'(cfg.kh) : '0;
				mul_b   = MUL_W'(item.yaw);
				state_d = ST_TSUM;
			end
			ST_TSUM:   state_d = ST_TDIV;
			ST_TDIV:   state_d = ST_DRIVE;
			ST_DRIVE: begin
				if (res_ready) begin
					done    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	assign idle = (state_q == ST_IDLE);

	// Loop state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bal_q   <= 1'b1;
			pend_q  <= 1'b0;
			spd_q   <= '0;
			trn_q   <= '0;
			filt_q  <= '0;
			integ_q <= '0;
		end else begin
			if (state_q == ST_CHECK) begin
				bal_q <= now_bal;
				if (bal_q && !now_bal) begin
					pend_q <= 1'b1;
				end
				if (now_bal) begin
					spd_q <= spd_new[4:0];
					trn_q <= trn_new[8:0];
				end else begin
					spd_q <= '0;
					trn_q <= '0;
				end
			end
			if (state_q == ST_FILT) begin
				filt_q <= filt_new;
			end
			if (state_q == ST_INTEG) begin
				if (pend_q) begin
					integ_q <= '0;
					pend_q  <= 1'b0;
				end else begin
					integ_q <= integ_new;
				end
			end
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_CHECK: begin
				fall_q <= !now_bal;
				hold_q <= !item.lft && !item.rgt;
			end
			ST_ERR: begin
				sign_q <= fsum[20];
				mag_q  <= 22'($unsigned(fsum_abs));
			end
			ST_SPD:    acc_q <= PROD_W'(spd_in);
			ST_VSCALE: begin
				sign_q <= prod[PROD_W-1];
				mag_q  <= prod_abs[KV_SHIFT+21:KV_SHIFT];
			end
			ST_VOUT:   v_q   <= v_new;
			ST_UPA:    acc_q <= PROD_W'(up_err);
			ST_UPD:    acc_q <= prod;
			ST_UPSUM:  acc_q <= acc_q + (prod <<< 8);
			ST_UPDIV: begin
				up_q  <= up_div[31:0];
				acc_q <= prod;
			end
			ST_TSUM:   acc_q <= acc_q + prod;
			ST_TDIV:   turn_q <= turn_div[31:0];
			default: ;
		endcase
	end

`ifndef ASSERT_OFF
	a_start_check: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && start) |=> (state_q == ST_CHECK))
		else $error("accepted item did not start the sequence");

	a_stay_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && !start) |=> (state_q == ST_IDLE))
		else $error("sequencer left idle without an item");

	a_integ_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INTEG && pend_q) |=> (integ_q == 16'sd0 && !pend_q))
		else $error("armed integral reset was not applied");

	a_integ_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INTEG) |=>
		(integ_q <= 16'(INTEGRAL_MAX) && integ_q >= -16'(INTEGRAL_MAX)))
		else $error("integral out of clamp range");

	a_drive_limit: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (17'(res.left) <= 17'(lim) && 17'(res.left) >= -17'(lim)
		&& 17'(res.right) <= 17'(lim) && 17'(res.right) >= -17'(lim)))
		else $error("drive exceeds motor limit");
`endif

endmodule

FILE: rtl/balance_robot_cascade_controller.sv
// An accepted item steps through every sequencer state on a balanced tick and from check
// straight to drive when fallen; new items stall until idle. All multiplies share one
// registered 28x28 multiplier that a sequencer steps through the three loops.
// The result sits in an output register, so the next item is taken while it waits.
// Reset (arst_n low, asynchronous) restores the configuration registers to defaults and
// clears the loop state; the sequencer resets to idle, so the block is ready after reset.
module balance_robot_cascade_controller import bcc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,

	// Input transaction
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic signed [15:0]    left_wheel_count,
	input  logic signed [15:0]    right_wheel_count,
	input  logic signed [16:0]    roll_angle,
	input  logic signed [15:0]    pitch_rate,
	input  logic signed [15:0]    yaw_rate,
	input  logic [11:0]           obstacle_distance,
	input  logic                  forward_button,
	input  logic                  backward_button,
	input  logic                  left_button,
	input  logic                  right_button,

	// Result transaction
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic signed [15:0]    left_motor_drive,
	output logic signed [15:0]    right_motor_drive,
	output logic                  is_balanced,

	// Configuration writes
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t  cfg;
	item_t item_q;
	res_t  res, res_q;
	logic  idle, done, start, res_ready, out_valid_q;

	// Registers are always writable; software must write only while the block is idle.
	assign cfg_ready = 1'b1;

	bcc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// An input transaction is taken only when the sequencer is idle. The fields are
	// captured here and held for the whole sequence.
	assign item_stall = !idle;
	assign start      = item_valid && !item_stall;

	always_ff @(posedge clk) begin
		if (start) begin
			item_q.left_count  <= left_wheel_count;
			item_q.right_count <= right_wheel_count;
			item_q.roll        <= roll_angle;
			item_q.pitch       <= pitch_rate;
			item_q.yaw         <= yaw_rate;
			item_q.obst_dist   <= obstacle_distance;
			item_q.fwd         <= forward_button;
			item_q.back        <= backward_button;
			item_q.lft         <= left_button;
			item_q.rgt         <= right_button;
		end
	end

	bcc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.item      (item_q),
		.cfg       (cfg),
		.res_ready (res_ready),
		.idle      (idle),
		.done      (done),
		.res       (res)
	);

	// Output register: the sequencer may finish a new result when the register is
	// empty or when its current result is being taken in this cycle.
	assign res_ready = !out_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			res_q <= res;
		end
	end

	assign result_valid      = out_valid_q;
	assign left_motor_drive  = res_q.left;
	assign right_motor_drive = res_q.right;
	assign is_balanced       = res_q.bal;

endmodule
